// ===== sv/tdcp_pkg.sv =====
// shared types, constants and keyword tables of the text drive command parser
// used by tdcp_parse, tdcp_result and text_drive_command_parser; no dependencies
package tdcp_pkg;

    // message length limit and the byte counter that saturates at it
    localparam int MAX_MESSAGE_BYTES = 256;
    localparam int CNT_W = $clog2(MAX_MESSAGE_BYTES + 1);

    // stream widths
    localparam int TDATA_W = 72;
    localparam int TUSER_W = 3;

    // command kinds
    localparam logic [2:0] KIND_NONE     = 3'd0;
    localparam logic [2:0] KIND_FORWARD  = 3'd1;
    localparam logic [2:0] KIND_BACKWARD = 3'd2;
    localparam logic [2:0] KIND_LEFT     = 3'd3;
    localparam logic [2:0] KIND_RIGHT    = 3'd4;
    localparam logic [2:0] KIND_STOP     = 3'd5;
    localparam logic [2:0] KIND_SPEED    = 3'd6;
    localparam logic [2:0] KIND_ANGLE    = 3'd7;

    // configuration register indexes
    localparam logic [1:0] CFG_MAX_SPEED    = 2'd0;
    localparam logic [1:0] CFG_STEER_LEFT   = 2'd1;
    localparam logic [1:0] CFG_STEER_RIGHT  = 2'd2;
    localparam logic [1:0] CFG_STEER_CENTER = 2'd3;

    localparam logic [14:0] MAX_SPEED_RESET = 15'd800;

    // keyword table: angle:, speed:, forward, backward, left, right, stop
    localparam int NUM_WORDS = 7;
    localparam logic [7:0] WORD_TEXT [0:6][0:7] = '{
        '{"a", "n", "g", "l", "e", ":", 8'd0, 8'd0},
        '{"s", "p", "e", "e", "d", ":", 8'd0, 8'd0},
        '{"f", "o", "r", "w", "a", "r", "d", 8'd0},
        '{"b", "a", "c", "k", "w", "a", "r", "d"},
        '{"l", "e", "f", "t", 8'd0, 8'd0, 8'd0, 8'd0},
        '{"r", "i", "g", "h", "t", 8'd0, 8'd0, 8'd0},
        '{"s", "t", "o", "p", 8'd0, 8'd0, 8'd0, 8'd0}
    };
    localparam logic [3:0] WORD_LEN [0:6] = '{4'd6, 4'd6, 4'd7, 4'd8, 4'd4, 4'd5, 4'd4};
    localparam logic [2:0] WORD_KIND [0:6] = '{
        KIND_ANGLE, KIND_SPEED, KIND_FORWARD, KIND_BACKWARD, KIND_LEFT, KIND_RIGHT, KIND_STOP
    };

    // link prefix, padded with zero bytes (a zero byte never reaches the prefix check)
    localparam logic [7:0] IPD_TEXT [0:7] = '{"+", "I", "P", "D", ",", 8'd0, 8'd0, 8'd0};
    localparam logic [2:0] IPD_LEN = 3'd5;

    // configuration registers as seen by the result stage
    typedef struct packed {
        logic [14:0] max_speed;
        logic [13:0] steer_left;
        logic [13:0] steer_right;
        logic [13:0] steer_center;
    } t_cfg;

    // end-of-message summary from the parser to the result stage
    typedef struct packed {
        logic        valid;
        logic [2:0]  kind;
        logic        negative;
        logic [15:0] magnitude;
    } t_msg;

endpackage

// ===== sv/tdcp_parse.sv =====
// per-byte parse state: white space skip, link prefix, keyword match, number scan
// depends on tdcp_pkg (keyword tables, t_msg)
module tdcp_parse (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output tdcp_pkg::t_msg   o_msg
);

    typedef enum logic [2:0] {
        PH_LEAD, PH_PREFIX, PH_COLON, PH_TRIM, PH_WORD, PH_NUM_LEAD, PH_NUM_DIGITS, PH_NUM_DONE
    } t_phase;

    localparam logic [tdcp_pkg::CNT_W-1:0] MAX_CNT =
        tdcp_pkg::CNT_W'(tdcp_pkg::MAX_MESSAGE_BYTES);

    t_phase                      r_phase, n_phase;
    logic [2:0]                  r_prefix_pos, n_prefix_pos;
    logic [6:0]                  r_alive, n_alive;
    logic [3:0]                  r_kpos, n_kpos;
    logic                        r_ended, n_ended;
    logic [15:0]                 r_mag, n_mag;
    logic                        r_neg, n_neg;
    logic [tdcp_pkg::CNT_W-1:0]  r_count, n_count;

    logic [6:0]                  w_alive;
    logic [3:0]                  w_kpos;
    logic                        w_to_num;
    logic                        apply_word;
    logic                        is_digit;
    logic [19:0]                 mag_x10;
    logic [tdcp_pkg::CNT_W-1:0]  cnt_inc;
    logic [2:0]                  kind;

    // keyword matcher step for the current byte
    always_comb begin
        w_alive = '0;
        for (int k = 0; k < tdcp_pkg::NUM_WORDS; k++) begin
            if (r_alive[k]) begin
                if (r_kpos < tdcp_pkg::WORD_LEN[k]) begin
                    if (tdcp_pkg::WORD_TEXT[k][r_kpos[2:0]] == i_byte) begin
                        w_alive[k] = 1'b1;
                    end
                end else if (k >= 2 && i_byte <= 8'd32) begin
                    w_alive[k] = 1'b1;
                end
            end
        end
        w_kpos   = (r_kpos == 4'd15) ? r_kpos : r_kpos + 4'd1;
        w_to_num = (|w_alive[1:0]) && (w_kpos == 4'd6);
    end

    // decimal accumulate, times ten by shift and add
    assign is_digit = (i_byte >= "0") && (i_byte <= "9");
    assign mag_x10  = {1'b0, r_mag, 3'b000} + {3'b000, r_mag, 1'b0} + {16'd0, i_byte[3:0]};
    assign cnt_inc  = (r_count < MAX_CNT) ? r_count + 1'b1 : r_count;

    // next parse state
    always_comb begin
        n_phase      = r_phase;
        n_prefix_pos = r_prefix_pos;
        n_alive      = r_alive;
        n_kpos       = r_kpos;
        n_ended      = r_ended;
        n_mag        = r_mag;
        n_neg        = r_neg;
        n_count      = r_count;
        apply_word   = 1'b0;
        if (i_accept && !r_ended) begin
            if (i_byte == 8'd0) begin
                n_ended = 1'b1;
            end else begin
                n_count = cnt_inc;
                if (cnt_inc < MAX_CNT) begin
                    unique case (r_phase)
                        PH_LEAD: begin
                            if (i_byte == 8'd13 || i_byte == 8'd10 || i_byte == 8'd32 ||
                                i_byte == 8'd9) begin
                                n_phase = r_phase;
                            end else if (i_byte == "+") begin
                                n_phase      = PH_PREFIX;
                                n_prefix_pos = 3'd1;
                            end else if (i_byte <= 8'd32) begin
                                n_phase = PH_TRIM;
                            end else begin
                                n_phase    = PH_WORD;
                                apply_word = 1'b1;
                            end
                        end
                        PH_PREFIX: begin
                            if (r_prefix_pos < tdcp_pkg::IPD_LEN &&
                                tdcp_pkg::IPD_TEXT[r_prefix_pos] == i_byte) begin
                                n_prefix_pos = r_prefix_pos + 3'd1;
                                if (r_prefix_pos + 3'd1 == tdcp_pkg::IPD_LEN) begin
                                    n_phase = PH_COLON;
                                end
                            end else begin
                                n_phase = PH_WORD;
                                n_alive = '0;
                            end
                        end
                        PH_COLON: begin
                            if (i_byte == ":") begin
                                n_phase = PH_TRIM;
                            end
                        end
                        PH_TRIM: begin
                            if (i_byte > 8'd32) begin
                                n_phase    = PH_WORD;
                                apply_word = 1'b1;
                            end
                        end
                        PH_WORD: begin
                            apply_word = 1'b1;
                        end
                        PH_NUM_LEAD: begin
                            if (i_byte == 8'd32 || (i_byte >= 8'd9 && i_byte <= 8'd13)) begin
                                n_phase = r_phase;
                            end else if (i_byte == "+" || i_byte == "-") begin
                                n_neg   = (i_byte == "-");
                                n_phase = PH_NUM_DIGITS;
                            end else if (is_digit) begin
                                n_mag   = {12'd0, i_byte[3:0]};
                                n_phase = PH_NUM_DIGITS;
                            end else begin
                                n_phase = PH_NUM_DONE;
                            end
                        end
                        PH_NUM_DIGITS: begin
                            if (is_digit) begin
                                n_mag = (mag_x10 > 20'd65535) ? 16'hFFFF : mag_x10[15:0];
                            end else begin
                                n_phase = PH_NUM_DONE;
                            end
                        end
                        PH_NUM_DONE: begin
                            n_phase = r_phase;
                        end
                        default: begin
                            n_phase = r_phase;
                        end
                    endcase
                    if (apply_word) begin
                        n_alive = w_alive;
                        n_kpos  = w_kpos;
                        if (w_to_num) begin
                            n_alive = {5'd0, w_alive[1:0]};
                            n_phase = PH_NUM_LEAD;
                        end
                    end
                end
            end
        end
    end

    // command kind from the state after the last byte
    always_comb begin
        kind = tdcp_pkg::KIND_NONE;
        if (n_count < MAX_CNT) begin
            if (n_phase == PH_WORD) begin
                for (int k = 2; k < tdcp_pkg::NUM_WORDS; k++) begin
                    if (n_alive[k] && n_kpos >= tdcp_pkg::WORD_LEN[k]) begin
                        kind = tdcp_pkg::WORD_KIND[k];
                    end
                end
            end else if (n_phase >= PH_NUM_LEAD) begin
                kind = n_alive[0] ? tdcp_pkg::KIND_ANGLE : tdcp_pkg::KIND_SPEED;
            end
        end
    end

    assign o_msg.valid     = i_accept && i_last;
    assign o_msg.kind      = kind;
    assign o_msg.negative  = n_neg;
    assign o_msg.magnitude = n_mag;

    // parse state, cleared after each message
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last)) begin
            r_phase      <= PH_LEAD;
            r_prefix_pos <= '0;
            r_alive      <= '1;
            r_kpos       <= '0;
            r_ended      <= 1'b0;
            r_mag        <= '0;
            r_neg        <= 1'b0;
            r_count      <= '0;
        end else begin
            r_phase      <= n_phase;
            r_prefix_pos <= n_prefix_pos;
            r_alive      <= n_alive;
            r_kpos       <= n_kpos;
            r_ended      <= n_ended;
            r_mag        <= n_mag;
            r_neg        <= n_neg;
            r_count      <= n_count;
        end
    end

    // parse state is back at its start after every message end
    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_last |=> r_phase == PH_LEAD && r_count == '0 && !r_ended)
        else $error("parse state not cleared after message end");

    // byte counter saturates at the limit
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("byte counter above message limit");

endmodule

// ===== sv/tdcp_result.sv =====
// result stage: duty computation, speed and angle stores, output register with a second slot
// depends on tdcp_pkg (t_msg, t_cfg, command kinds)
module tdcp_result (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tdcp_pkg::t_msg                i_msg,
    input  tdcp_pkg::t_cfg                i_cfg,
    input  logic                          i_m_tready,
    output logic                          o_ready,
    output logic                          o_m_tvalid,
    output logic [tdcp_pkg::TDATA_W-1:0]  o_m_tdata,
    output logic [tdcp_pkg::TUSER_W-1:0]  o_m_tuser
);

    logic                          r_valid;
    logic [tdcp_pkg::TDATA_W-1:0]  r_tdata, n_tdata;
    logic [tdcp_pkg::TUSER_W-1:0]  r_tuser;
    logic                          r_skid_valid;
    logic [tdcp_pkg::TDATA_W-1:0]  r_skid_tdata;
    logic [tdcp_pkg::TUSER_W-1:0]  r_skid_tuser;
    logic signed [15:0]            r_speed, n_speed;
    logic signed [16:0]            r_angle, n_angle;

    logic                          out_held;
    logic [16:0]                   mag_neg;
    logic signed [15:0]            value;
    logic signed [16:0]            value_x, max_x, clamped;
    logic signed [17:0]            angle_sum;
    logic                          motor_upd, steer_upd;
    logic signed [15:0]            motor;
    logic signed [16:0]            steer;

    // saturated signed number
    always_comb begin
        mag_neg = (i_msg.magnitude > 16'd32768) ? 17'd32768 : {1'b0, i_msg.magnitude};
        if (i_msg.negative) begin
            value = 16'(-mag_neg);
        end else begin
            value = (i_msg.magnitude > 16'd32767) ? 16'sd32767 : i_msg.magnitude;
        end
        value_x = {value[15], value};
        max_x   = {2'b00, i_cfg.max_speed};
        if (value_x > max_x) begin
            clamped = max_x;
        end else if (value_x < -max_x) begin
            clamped = -max_x;
        end else begin
            clamped = value_x;
        end
        angle_sum = {4'd0, i_cfg.steer_left} + {4'd0, i_cfg.steer_right} - {{2{value[15]}}, value};
    end

    // duties and store updates per command kind
    always_comb begin
        motor_upd = 1'b0;
        steer_upd = 1'b0;
        motor     = '0;
        steer     = '0;
        n_angle   = r_angle;
        case (i_msg.kind)
            tdcp_pkg::KIND_FORWARD: begin
                motor_upd = 1'b1;
                motor     = {1'b0, i_cfg.max_speed};
            end
            tdcp_pkg::KIND_BACKWARD: begin
                motor_upd = 1'b1;
                motor     = -{1'b0, i_cfg.max_speed};
            end
            tdcp_pkg::KIND_LEFT: begin
                steer_upd = 1'b1;
                steer     = {3'd0, i_cfg.steer_left};
                n_angle   = steer;
            end
            tdcp_pkg::KIND_RIGHT: begin
                steer_upd = 1'b1;
                steer     = {3'd0, i_cfg.steer_right};
                n_angle   = steer;
            end
            tdcp_pkg::KIND_STOP: begin
                motor_upd = 1'b1;
                steer_upd = 1'b1;
                steer     = {3'd0, i_cfg.steer_center};
                n_angle   = steer;
            end
            tdcp_pkg::KIND_SPEED: begin
                motor_upd = 1'b1;
                motor     = clamped[15:0];
            end
            tdcp_pkg::KIND_ANGLE: begin
                steer_upd = 1'b1;
                steer     = angle_sum[16:0];
                n_angle   = {value[15], value};
            end
            default: begin
                motor_upd = 1'b0;
            end
        endcase
        n_speed = motor_upd ? motor : r_speed;
        n_tdata = {4'd0, n_angle, n_speed, steer, steer_upd, motor, motor_upd};
    end

    // output register waiting on the m side; input stalls only while the second slot is full
    assign out_held   = r_valid && !i_m_tready;
    assign o_ready    = !r_skid_valid;
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_tdata;
    assign o_m_tuser  = r_tuser;

    // stores, output register and second slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
            r_speed      <= '0;
            r_angle      <= '0;
        end else begin
            if (i_msg.valid) begin
                r_speed <= n_speed;
                r_angle <= n_angle;
            end
            if (out_held) begin
                if (i_msg.valid) begin
                    r_skid_valid <= 1'b1;
                end
            end else if (r_skid_valid) begin
                r_valid      <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_valid <= i_msg.valid;
            end
        end
        if (out_held) begin
            if (i_msg.valid) begin
                r_skid_tdata <= n_tdata;
                r_skid_tuser <= i_msg.kind;
            end
        end else if (r_skid_valid) begin
            r_tdata <= r_skid_tdata;
            r_tuser <= r_skid_tuser;
        end else if (i_msg.valid) begin
            r_tdata <= n_tdata;
            r_tuser <= i_msg.kind;
        end
    end

    // an ignored message applies nothing
    a_none_no_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_tuser == tdcp_pkg::KIND_NONE |-> !r_tdata[0] && !r_tdata[17])
        else $error("ignored message carries an update");

    // unused duty fields read as zero
    a_idle_duty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_tdata[0] || r_tdata[16:1] == '0) && (r_tdata[17] || r_tdata[34:18] == '0))
        else $error("duty field nonzero without update");

    // a finished message always leaves the output register valid on the next cycle
    a_msg_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_msg.valid |=> r_valid)
        else $error("message end did not load the output register");

    // no message ends while the second slot is full
    a_skid_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_msg.valid)
        else $error("message end while both output slots are full");

endmodule

// ===== sv/text_drive_command_parser.sv =====
// top level of the text drive command parser: stream ports, configuration registers
// depends on tdcp_pkg, tdcp_parse and tdcp_result
//
// Takes one message byte per transfer on the s side (tlast marks the last byte) and
// gives one result transfer per message on the m side. The parse state updates in
// the cycle of the transfer and the result of a message is computed from the final
// state in that same cycle, so bytes can stream back to back and the result appears
// on the m side in the cycle after the last byte when the output register is free.
// The output stage holds two results: a result that finds the output register still
// waiting on the m side goes into a second slot, and the s side stalls (tready low,
// driven from a register) only while that second slot is full.
// Configuration writes are always taken and must only happen while no message is in
// progress.
module text_drive_command_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input byte stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [7:0]                    i_s_tdata,   // [7:0] in_byte
    input  logic                          i_s_tlast,   // msg_end
    // result stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [0] motor_update, [16:1] motor_duty, [17] steer_update, [34:18] steer_duty,
    // [50:35] speed_now, [67:51] angle_now, [71:68] zero
    output logic [tdcp_pkg::TDATA_W-1:0]  o_m_tdata,
    output logic [tdcp_pkg::TUSER_W-1:0]  o_m_tuser,   // [2:0] cmd_kind
    // configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [14:0]                   i_cfg_data
);

    tdcp_pkg::t_cfg  r_cfg;
    tdcp_pkg::t_msg  msg;
    logic            ready;
    logic            in_xfer;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = ready;
    assign in_xfer     = i_s_tvalid && ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_speed    <= tdcp_pkg::MAX_SPEED_RESET;
            r_cfg.steer_left   <= '0;
            r_cfg.steer_right  <= '0;
            r_cfg.steer_center <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tdcp_pkg::CFG_MAX_SPEED:    r_cfg.max_speed    <= i_cfg_data;
                tdcp_pkg::CFG_STEER_LEFT:   r_cfg.steer_left   <= i_cfg_data[13:0];
                tdcp_pkg::CFG_STEER_RIGHT:  r_cfg.steer_right  <= i_cfg_data[13:0];
                tdcp_pkg::CFG_STEER_CENTER: r_cfg.steer_center <= i_cfg_data[13:0];
                default:                    r_cfg.max_speed    <= r_cfg.max_speed;
            endcase
        end
    end

    tdcp_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_xfer),
        .i_byte   (i_s_tdata),
        .i_last   (i_s_tlast),
        .o_msg    (msg)
    );

    tdcp_result u_result (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_msg      (msg),
        .i_cfg      (r_cfg),
        .i_m_tready (i_m_tready),
        .o_ready    (ready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
